@@ hdl/pau_pkg.sv @@
// Shared constants and types for the polynomial arithmetic unit.
`timescale 1ns / 1ps

package pau_pkg;

    // Operand store geometry
    localparam int MAX_TERMS = 32;
    localparam int ADDR_W    = $clog2(MAX_TERMS);
    localparam int COEF_W    = 32;
    localparam int POW_W     = 5;
    localparam int RES_POW_W = 6;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int IN_FIELD_W  = POW_W + COEF_W;
    localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = RES_POW_W + COEF_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Operation register codes; the unused code acts as add
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // Operand select codes
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    // Sequencer to arithmetic unit: operands arriving from the stores
    typedef struct packed {
        logic load;   // store read data valid this cycle
        logic last;   // final operand pair of this power
        logic a_ok;   // A entry was written since the fresh load
        logic b_ok;   // B entry was written since the fresh load
        logic clear;  // start a new sum
    } mac_ctrl_t;

    // Arithmetic unit to sequencer
    typedef struct packed {
        logic              done;  // sum of the current power is complete
        logic [COEF_W-1:0] sum;
    } mac_stat_t;

endpackage

@@ hdl/polynomial_arithmetic_unit_top.sv @@
// Polynomial add, subtract and multiply over streamed dense coefficients.
// Loads: one term per cycle while idle; a term of A or a B term without tlast gives no beats.
// Add/subtract: degree+1 result beats, highest power first.
// Multiply: for each power p, every index pair summing to p goes through the single
//   shared multiply-accumulate unit, fed from two coefficient RAMs.
// Reset (rst_n, async, low) clears the sequencer, degrees, valid bits and operation.
`timescale 1ns / 1ps

module polynomial_arithmetic_unit_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // Operation register write
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_wdata,
    // Term input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [pau_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // term_power, term_coef, zero pad
    input  logic                           s_axis_tuser,  // poly_select
    input  logic                           s_axis_tlast,  // last_term
    // Result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [pau_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // result_power, result_coef, zero pad
    output logic                            m_axis_tlast  // result_last
);

    import pau_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TOP   = 6'b000010,
        S_PWR   = 6'b000100,
        S_ISSUE = 6'b001000,
        S_DRAIN = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]           op_reg;
    logic                 fresh_reg;
    logic [POW_W-1:0]     deg_a_reg, deg_a_next;
    logic [POW_W-1:0]     deg_b_reg, deg_b_next;
    logic [MAX_TERMS-1:0] valid_a_reg, valid_a_next;
    logic [MAX_TERMS-1:0] valid_b_reg, valid_b_next;
    logic [RES_POW_W-1:0] p_reg;
    logic [ADDR_W-1:0]    i_reg;
    logic [ADDR_W-1:0]    hi_reg;
    logic [COEF_W-1:0]    out_coef_reg;
    logic                 s1_v_reg, s1_last_reg, a_ok_reg, b_ok_reg;

    logic                 in_beat, out_beat, start;
    logic                 in_sel, in_last;
    logic [POW_W-1:0]     in_pow;
    logic [COEF_W-1:0]    in_coef;
    logic                 is_mul;
    logic [RES_POW_W-1:0] top;
    logic [RES_POW_W-1:0] deg_a_x, deg_b_x;
    logic [RES_POW_W-1:0] lo_diff, b_diff;
    logic [ADDR_W-1:0]    lo, hi;
    logic [ADDR_W-1:0]    ra_addr, rb_addr;
    logic [COEF_W-1:0]    a_rdata, b_rdata;
    logic [POW_W-1:0]     base_a, base_b;
    logic [MAX_TERMS-1:0] vbase_a, vbase_b, pow_bit;
    mac_ctrl_t            mctrl;
    mac_stat_t            mstat;

    // Input unpacking
    assign in_sel  = s_axis_tuser;
    assign in_last = s_axis_tlast;
    assign in_pow  = s_axis_tdata[POW_W-1:0];
    assign in_coef = s_axis_tdata[POW_W +: COEF_W];

    assign in_beat  = s_axis_tvalid & s_axis_tready;
    assign out_beat = m_axis_tvalid & m_axis_tready;
    assign start    = in_beat & (in_sel == SEL_B) & in_last;
    assign is_mul   = (op_reg == OP_MUL);

    // Degree and valid-bit update; a fresh load starts from an empty store
    always_comb
    begin
        base_a  = fresh_reg ? '0 : deg_a_reg;
        base_b  = fresh_reg ? '0 : deg_b_reg;
        vbase_a = fresh_reg ? '0 : valid_a_reg;
        vbase_b = fresh_reg ? '0 : valid_b_reg;
        pow_bit = '0;
        pow_bit[in_pow[ADDR_W-1:0]] = 1'b1;
        deg_a_next   = base_a;
        deg_b_next   = base_b;
        valid_a_next = vbase_a;
        valid_b_next = vbase_b;
        if (in_sel == SEL_A)
        begin
            valid_a_next = vbase_a | pow_bit;
            if (in_pow > base_a)
            begin
                deg_a_next = in_pow;
            end
        end
        else
        begin
            valid_b_next = vbase_b | pow_bit;
            if (in_pow > base_b)
            begin
                deg_b_next = in_pow;
            end
        end
    end

    // Highest result power and the term range for power p
    assign deg_a_x = {1'b0, deg_a_reg};
    assign deg_b_x = {1'b0, deg_b_reg};
    assign top     = is_mul ? (deg_a_x + deg_b_x)
                            : ((deg_a_reg > deg_b_reg) ? deg_a_x : deg_b_x);
    assign lo_diff = p_reg - deg_b_x;
    assign lo      = (is_mul && (p_reg > deg_b_x)) ? lo_diff[ADDR_W-1:0] : '0;
    assign hi      = !is_mul ? '0 : ((p_reg > deg_a_x) ? deg_a_reg : p_reg[ADDR_W-1:0]);

    // Store read addresses
    assign b_diff  = p_reg - {1'b0, i_reg};
    assign ra_addr = is_mul ? i_reg : p_reg[ADDR_W-1:0];
    assign rb_addr = is_mul ? b_diff[ADDR_W-1:0] : p_reg[ADDR_W-1:0];

    pau_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_ram_a (
        .clk   (clk),
        .we    (in_beat && (in_sel == SEL_A)),
        .waddr (in_pow[ADDR_W-1:0]),
        .wdata (in_coef),
        .raddr (ra_addr),
        .rdata (a_rdata)
    );

    pau_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_ram_b (
        .clk   (clk),
        .we    (in_beat && (in_sel == SEL_B)),
        .waddr (in_pow[ADDR_W-1:0]),
        .wdata (in_coef),
        .raddr (rb_addr),
        .rdata (b_rdata)
    );

    assign mctrl.load  = s1_v_reg;
    assign mctrl.last  = s1_last_reg;
    assign mctrl.a_ok  = a_ok_reg;
    assign mctrl.b_ok  = b_ok_reg;
    assign mctrl.clear = (state_reg == S_PWR);

    pau_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op_reg),
        .ctrl   (mctrl),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .stat   (mstat)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_TOP;
            S_TOP:   state_next = S_PWR;
            S_PWR:   state_next = S_ISSUE;
            S_ISSUE: if (i_reg == hi_reg) state_next = S_DRAIN;
            S_DRAIN: if (mstat.done) state_next = S_OUT;
            S_OUT:
            begin
                if (out_beat)
                begin
                    state_next = (p_reg == '0) ? S_IDLE : S_PWR;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_ADD;
            fresh_reg   <= 1'b1;
            deg_a_reg   <= '0;
            deg_b_reg   <= '0;
            valid_a_reg <= '0;
            valid_b_reg <= '0;
            s1_v_reg    <= 1'b0;
            s1_last_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            s1_v_reg    <= (state_reg == S_ISSUE);
            s1_last_reg <= (state_reg == S_ISSUE) && (i_reg == hi_reg);
            if (cfg_we)
            begin
                op_reg <= cfg_wdata;
            end
            if (in_beat)
            begin
                fresh_reg   <= 1'b0;
                deg_a_reg   <= deg_a_next;
                deg_b_reg   <= deg_b_next;
                valid_a_reg <= valid_a_next;
                valid_b_reg <= valid_b_next;
            end
            else if (out_beat && (p_reg == '0))
            begin
                fresh_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TOP)
        begin
            p_reg <= top;
        end
        else if ((state_reg == S_OUT) && out_beat)
        begin
            p_reg <= p_reg - RES_POW_W'(1);
        end
        if (state_reg == S_PWR)
        begin
            i_reg  <= lo;
            hi_reg <= hi;
        end
        else if (state_reg == S_ISSUE)
        begin
            i_reg <= i_reg + ADDR_W'(1);
        end
        if (state_reg == S_ISSUE)
        begin
            a_ok_reg <= valid_a_reg[ra_addr];
            b_ok_reg <= valid_b_reg[rb_addr];
        end
        if ((state_reg == S_DRAIN) && mstat.done)
        begin
            out_coef_reg <= mstat.sum;
        end
    end

    // Output beat
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, out_coef_reg, p_reg};
    assign m_axis_tlast  = (p_reg == '0);

endmodule

@@ hdl/pau_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pau_mac.sv @@
// Shared arithmetic unit: add, subtract or multiply, then accumulate.
`timescale 1ns / 1ps

module pau_mac (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [1:0]                op,
    input  pau_pkg::mac_ctrl_t        ctrl,
    input  logic [pau_pkg::COEF_W-1:0] a_data,
    input  logic [pau_pkg::COEF_W-1:0] b_data,
    output pau_pkg::mac_stat_t        stat
);

    import pau_pkg::*;

    logic [COEF_W-1:0]   a_eff;
    logic [COEF_W-1:0]   b_eff;
    logic [2*COEF_W-1:0] prod_full;
    logic [COEF_W-1:0]   val_next;
    logic [COEF_W-1:0]   val_reg;
    logic                v_reg;
    logic                last_reg;
    logic [COEF_W-1:0]   acc_reg;
    logic [COEF_W-1:0]   acc_next;

    // Entries not written since the fresh load read as zero
    assign a_eff     = ctrl.a_ok ? a_data : '0;
    assign b_eff     = ctrl.b_ok ? b_data : '0;
    assign prod_full = a_eff * b_eff;

    always_comb
    begin
        case (op)
            OP_MUL:  val_next = prod_full[COEF_W-1:0];
            OP_SUB:  val_next = a_eff - b_eff;
            default: val_next = a_eff + b_eff;
        endcase
    end

    // Operation stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= ctrl.load;
            last_reg <= ctrl.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            val_reg <= val_next;
        end
    end

    // Accumulator, wraps at 32 bits
    assign acc_next = acc_reg + val_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (v_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign stat.done = v_reg & last_reg;
    assign stat.sum  = acc_next;

endmodule

@@ hdl/pau_chk.sv @@
// Port-level checks for the polynomial arithmetic unit, bound to the top level.
`timescale 1ns / 1ps

module pau_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pau_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    import pau_pkg::*;

    // Loading and result delivery never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is offered");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // tlast marks exactly the power-zero coefficient
    a_last_pow0: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[RES_POW_W-1:0] == '0)))
        else $error("tlast does not match power zero");

    // The final B term starts a computation
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == SEL_B) && s_axis_tlast
        |=> !s_axis_tready)
        else $error("input still ready after the final B term");

    // After the last result beat the block loads again
    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("input not ready after the final result beat");

endmodule

bind polynomial_arithmetic_unit_top pau_chk u_pau_chk (.*);
